/* design/gs_pkg.sv */
package gs_pkg;

   localparam int DATA_W    = 32;
   localparam int IDX_W     = 4;
   localparam int SIZE_W    = 5;
   localparam int RES_LIMIT = 16;
   localparam int ACC_W     = 64;
   localparam int QUOT_W    = 63;
   localparam int CSR_AW    = 3;

   localparam logic [1:0] OP_MATRIX = 2'd0;
   localparam logic [1:0] OP_RHS    = 2'd1;
   localparam logic [1:0] OP_SOLVE  = 2'd2;

   localparam logic REG_MATRIX_SIZE = 1'b0;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [IDX_W-1:0]        row_index;
      logic [IDX_W-1:0]        col_index;
      logic signed [DATA_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [IDX_W-1:0]        result_index;
      logic signed [DATA_W-1:0] result_value;
      logic                    last;
   } rsp_word_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* design/gs_div.sv */
module gs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gs_pkg::QUOT_W-1:0]     num,
   input  logic [gs_pkg::DATA_W-1:0]     den,
   output gs_pkg::div_status_type        status,
   output logic [gs_pkg::QUOT_W-1:0]     quot
);

   localparam int CNT_W = $clog2(gs_pkg::QUOT_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [gs_pkg::DATA_W-1:0]   rem_ff, rem_in;
   logic [gs_pkg::QUOT_W-1:0]   nq_ff, nq_in;
   logic [gs_pkg::DATA_W-1:0]   den_ff, den_in;
   logic [gs_pkg::DATA_W:0]     rem_sh;
   logic [gs_pkg::DATA_W:0]     diff;
   logic                        qbit;

   assign rem_sh = {rem_ff, nq_ff[gs_pkg::QUOT_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign qbit   = ~diff[gs_pkg::DATA_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      nq_in   = nq_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         nq_in   = num;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = qbit ? diff[gs_pkg::DATA_W-1:0] : rem_sh[gs_pkg::DATA_W-1:0];
         nq_in  = {nq_ff[gs_pkg::QUOT_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(gs_pkg::QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      den_ff <= den_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = nq_ff;

endmodule

/* design/gauss_seidel_solver.sv */
// Load words (matrix or right-hand side entry) are taken one per cycle while idle.
// A solve clears x, then runs n sweeps of n rows: a multiply-accumulate pass plus
// a bit-serial divide, skipped for a zero diagonal. It then emits one word per
// entry of x, held under rsp_stall. The divider sets the row time for small n.
// Synchronous reset returns the sequencer to idle and matrix_size to 1.
module gauss_seidel_solver #(
   parameter int MAX_DIM   = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gs_pkg::req_word_type         req_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gs_pkg::rsp_word_type         rsp_word,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [gs_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int IW  = $clog2(MAX_DIM);
   localparam int AW  = 2 * IW;
   localparam int LIM = (MAX_DIM < gs_pkg::RES_LIMIT) ? MAX_DIM : gs_pkg::RES_LIMIT;
   localparam logic signed [gs_pkg::ACC_W-1:0] BOUND =
      gs_pkg::ACC_W'(64'sd1 <<< (62 - FRAC_BITS));

   typedef enum logic [9:0] {
      ST_IDLE      = 10'b0000000001,
      ST_CLEAR     = 10'b0000000010,
      ST_ROW       = 10'b0000000100,
      ST_DRAIN     = 10'b0000001000,
      ST_START     = 10'b0000010000,
      ST_DIV       = 10'b0000100000,
      ST_UPD       = 10'b0001000000,
      ST_EMIT_RD   = 10'b0010000000,
      ST_EMIT_WAIT = 10'b0100000000,
      ST_SPARE     = 10'b1000000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [gs_pkg::SIZE_W-1:0]          size_ff, size_in;
   logic [gs_pkg::SIZE_W-1:0]          n_ff, n_in;
   logic [gs_pkg::SIZE_W-1:0]          sweep_ff, sweep_in;
   logic [gs_pkg::IDX_W-1:0]           row_ff, row_in;
   logic [gs_pkg::IDX_W-1:0]           col_ff, col_in;
   logic                               s1_v_ff, s2_v_ff;
   logic [gs_pkg::IDX_W-1:0]           s1_j_ff;
   logic signed [gs_pkg::ACC_W-1:0]    prod_ff, prod_in;
   logic signed [gs_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [gs_pkg::DATA_W-1:0]   diag_ff, diag_in;
   logic signed [gs_pkg::DATA_W-1:0]   xold_ff, xold_in;
   logic signed [gs_pkg::DATA_W-1:0]   b_ff, b_in;
   logic signed [gs_pkg::ACC_W-1:0]    r_ff, r_in;
   logic                               neg_ff, neg_in;
   logic signed [gs_pkg::DATA_W-1:0]   q_ff, q_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   gs_pkg::rsp_word_type               rsp_word_ff, rsp_word_in;

   logic signed [gs_pkg::DATA_W-1:0]   coeff_mem [2**AW];
   logic signed [gs_pkg::DATA_W-1:0]   rhs_mem [MAX_DIM];
   logic signed [gs_pkg::DATA_W-1:0]   x_mem [MAX_DIM];
   logic signed [gs_pkg::DATA_W-1:0]   coeff_q, rhs_q, x_q;

   logic                               accept, in_range_row, in_range_col;
   logic                               csr_write;
   logic [gs_pkg::SIZE_W-1:0]          n_eff;
   logic [gs_pkg::IDX_W-1:0]           nm1;
   logic                               x_we;
   logic [IW-1:0]                      x_wa;
   logic signed [gs_pkg::DATA_W-1:0]   x_wd;
   logic signed [gs_pkg::ACC_W-1:0]    r_raw, r_mag;
   logic [gs_pkg::DATA_W-1:0]          den_mag;
   logic                               div_start;
   gs_pkg::div_status_type             div_status;
   logic [gs_pkg::QUOT_W-1:0]          div_num, div_quot;
   logic signed [gs_pkg::DATA_W:0]     x_sum;
   logic                               rsp_load;

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != ST_IDLE);
   assign in_range_row = (32'(req_word.row_index) < MAX_DIM);
   assign in_range_col = (32'(req_word.col_index) < MAX_DIM);
   assign n_eff        = (32'(size_ff) > LIM) ? gs_pkg::SIZE_W'(LIM) : size_ff;
   assign nm1          = gs_pkg::IDX_W'(n_ff - 1'b1);

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == gs_pkg::REG_MATRIX_SIZE) ? 32'(size_ff) : '0;
   assign size_in    = (csr_write && csr_paddr[2] == gs_pkg::REG_MATRIX_SIZE) ?
                       csr_pwdata[gs_pkg::SIZE_W-1:0] : size_ff;

   always_ff @(posedge clock) begin
      if (accept && req_word.opcode == gs_pkg::OP_MATRIX && in_range_row && in_range_col) begin
         coeff_mem[{IW'(req_word.row_index), IW'(req_word.col_index)}] <= req_word.value;
      end
      coeff_q <= coeff_mem[{IW'(row_ff), IW'(col_ff)}];
   end

   always_ff @(posedge clock) begin
      if (accept && req_word.opcode == gs_pkg::OP_RHS && in_range_row) begin
         rhs_mem[IW'(req_word.row_index)] <= req_word.value;
      end
      rhs_q <= rhs_mem[IW'(row_ff)];
   end

   always_ff @(posedge clock) begin
      if (x_we) begin
         x_mem[x_wa] <= x_wd;
      end
      x_q <= x_mem[IW'(col_ff)];
   end

   assign r_raw   = gs_pkg::ACC_W'(b_ff) - acc_ff;
   assign r_mag   = r_ff[gs_pkg::ACC_W-1] ? -r_ff : r_ff;
   assign div_num = gs_pkg::QUOT_W'(r_mag <<< FRAC_BITS);
   assign den_mag = diag_ff[gs_pkg::DATA_W-1] ? gs_pkg::DATA_W'(-diag_ff) :
                    gs_pkg::DATA_W'(diag_ff);
   assign x_sum   = (gs_pkg::DATA_W+1)'(xold_ff) + (gs_pkg::DATA_W+1)'(q_ff);
   assign rsp_load = !rsp_valid_ff || !rsp_stall;

   gs_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (den_mag),
      .status (div_status),
      .quot   (div_quot)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      sweep_in     = sweep_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      r_in         = r_ff;
      neg_in       = neg_ff;
      q_in         = q_ff;
      x_we         = 1'b0;
      x_wa         = IW'(col_ff);
      x_wd         = '0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      prod_in      = coeff_q * x_q;
      diag_in      = diag_ff;
      xold_in      = xold_ff;
      b_in         = b_ff;
      acc_in       = '0;

      if (s1_v_ff) begin
         if (s1_j_ff == row_ff) begin
            diag_in = coeff_q;
            xold_in = x_q;
         end
         if (s1_j_ff == '0) begin
            b_in = rhs_q;
         end
      end
      if (state_ff == ST_ROW || state_ff == ST_DRAIN) begin
         acc_in = s2_v_ff ? acc_ff + (prod_ff >>> FRAC_BITS) : acc_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_word.opcode == gs_pkg::OP_SOLVE && n_eff != '0) begin
               n_in     = n_eff;
               col_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            x_we = 1'b1;
            if (col_ff == nm1) begin
               col_in   = '0;
               row_in   = '0;
               sweep_in = '0;
               state_in = ST_ROW;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_ROW: begin
            if (col_ff == nm1) begin
               col_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               if (r_raw > BOUND) begin
                  r_in = BOUND;
               end else if (r_raw < -BOUND) begin
                  r_in = -BOUND;
               end else begin
                  r_in = r_raw;
               end
               state_in = (diag_ff == '0) ? ST_UPD : ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            neg_in    = r_ff[gs_pkg::ACC_W-1] ^ diag_ff[gs_pkg::DATA_W-1];
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (neg_ff) begin
                  q_in = (div_quot > gs_pkg::QUOT_W'(33'h080000000)) ?
                         {1'b1, {(gs_pkg::DATA_W-1){1'b0}}} :
                         -(div_quot[gs_pkg::DATA_W-1:0]);
               end else begin
                  q_in = (div_quot > gs_pkg::QUOT_W'(33'h07fffffff)) ?
                         {1'b0, {(gs_pkg::DATA_W-1){1'b1}}} :
                         div_quot[gs_pkg::DATA_W-1:0];
               end
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (diag_ff != '0) begin
               x_we = 1'b1;
               x_wa = IW'(row_ff);
               if (x_sum[gs_pkg::DATA_W] != x_sum[gs_pkg::DATA_W-1]) begin
                  x_wd = {x_sum[gs_pkg::DATA_W], {(gs_pkg::DATA_W-1){~x_sum[gs_pkg::DATA_W]}}};
               end else begin
                  x_wd = x_sum[gs_pkg::DATA_W-1:0];
               end
            end
            col_in = '0;
            if (row_ff == nm1) begin
               row_in = '0;
               if (sweep_ff == n_ff - 1'b1) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
                  state_in = ST_ROW;
               end
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (rsp_load) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.result_index  = col_ff;
               rsp_word_in.result_value  = x_q;
               rsp_word_in.last          = (col_ff == nm1);
               if (col_ff == nm1) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= gs_pkg::SIZE_W'(1);
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         s1_v_ff      <= (state_ff == ST_ROW);
         s2_v_ff      <= s1_v_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      sweep_ff    <= sweep_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      s1_j_ff     <= col_ff;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      diag_ff     <= diag_in;
      xold_ff     <= xold_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      neg_ff      <= neg_in;
      q_ff        <= q_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> state_ff == ST_DIV)
      else $error("divider busy outside divide state");

   a_div_state_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_status.busy || div_status.done)
      else $error("divide state without running divider");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT_WAIT))
      else $error("result word raised outside emit");

endmodule
